### design/boxblur_pkg.sv
// Shared types and constants for the 3x3 edge-averaging box blur.
// Holds the divisor codes, register indexes and reset values.
// Depends on nothing; the top level refers to it by scoped names.
`default_nettype none

package boxblur_pkg;

  // Number of in-grid points in a neighborhood: corner, edge or interior.
  typedef enum logic [1:0] {
    DIV_BY_4,
    DIV_BY_6,
    DIV_BY_9
  } div_t;

  // Register index as decoded from paddr[2].
  localparam logic REG_GRID_COLS = 1'b0;
  localparam logic REG_GRID_ROWS = 1'b1;

  localparam int ROW_BITS = 16;

  localparam logic [10:0]         GRID_COLS_RST = 11'd33;
  localparam logic [ROW_BITS-1:0] GRID_ROWS_RST = 16'd33;

endpackage

`default_nettype wire

### design/box_blur_3x3_edge_average.sv
// 3x3 box blur with edge averaging over a raster-order height stream.
// Uses boxblur_pkg for divisor codes, register indexes and reset values.
// Holds the line memory, the column window and the rounding divider pipeline.
//
// Usage
//   Input words (in_valid / in_stall) carry a command bit and a signed
//   height. Command 0 is a sample, command 1 a flush tick. A word moves at a
//   rising edge where valid is high and stall is low. Result words
//   (out_valid / out_stall) carry the rounded neighborhood mean and a flag
//   that marks the final point of the grid.
//   The grid size is set through the APB-style port: grid_cols at byte
//   address 0 and grid_rows at byte address 4. Any write restarts the stream.
//   The result for a point is released by the sample one row plus one point
//   later; after the last sample, one flush per pending point drains the
//   rest. Flushes before the grid is complete are dropped without a result.
//   Throughput is one word per clock while in_stall is low. On its way to
//   the output register a result passes the line memory read, the column
//   add, the rounding step and the two-stage reciprocal multiply.
//   When the receiver stalls, the output register holds its word and the
//   pipeline behind it keeps filling; input stall rises only once every
//   stage back to the memory read stage is occupied.
//   Reset (rst_n low at a clock edge) sets both registers to 33 and empties
//   the stream. The line memory needs no clearing: rows outside the grid are
//   masked, so no entry is read before the current grid has written it.
`default_nettype none

module box_blur_3x3_edge_average #(
  parameter int MAX_COLS    = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input channel.
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_command,
  input  logic signed [SAMPLE_BITS-1:0] in_height,
  // Result channel.
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_smoothed,
  output logic                          out_grid_done,
  // Configuration port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int SB    = SAMPLE_BITS;
  localparam int AW    = $clog2(MAX_COLS);        // column index
  localparam int CW    = $clog2(MAX_COLS + 1);    // column count
  localparam int PDW   = $clog2(MAX_COLS + 2);    // pending count, up to cols + 1
  localparam int RW    = boxblur_pkg::ROW_BITS;
  localparam int CSW   = SB + 2;                  // sum of one column of three
  localparam int TW    = SB + 4;                  // sum of nine, signed
  localparam int NW    = SB + 3;                  // rounded magnitude
  localparam int SHIFT = SB + 8;                  // reciprocal scale
  localparam int KW    = SB + 7;                  // reciprocal width
  localparam int KLW   = KW / 2;
  localparam int KHW   = KW - KLW;
  localparam int PW    = NW + KW;                 // full product width
  localparam int QW    = PW - SHIFT;              // quotient width

  // Rounded-up reciprocals. With n below 2^(SB+3) and the rounding error of
  // each constant at most 8, (n * K) >> SHIFT is the exact floor of n / d.
  localparam logic [63:0]   ONE_S = 64'd1 << SHIFT;
  localparam logic [KW-1:0] K4    = KW'(ONE_S / 64'd4);
  localparam logic [KW-1:0] K6    = KW'((ONE_S + 64'd5) / 64'd6);
  localparam logic [KW-1:0] K9    = KW'((ONE_S + 64'd8) / 64'd9);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [10:0]   grid_cols_r;
  logic [RW-1:0] grid_rows_r;
  logic          cfg_wr;
  logic [CW-1:0] cols_eff;
  logic [RW-1:0] rows_eff;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_cols_r <= boxblur_pkg::GRID_COLS_RST;
      grid_rows_r <= boxblur_pkg::GRID_ROWS_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        boxblur_pkg::REG_GRID_COLS: grid_cols_r <= pwdata[10:0];
        boxblur_pkg::REG_GRID_ROWS: grid_rows_r <= pwdata[RW-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      boxblur_pkg::REG_GRID_COLS: prdata = {21'd0, grid_cols_r};
      boxblur_pkg::REG_GRID_ROWS: prdata = {16'd0, grid_rows_r};
    endcase
  end

  // Out-of-range sizes are clamped: below 3 to 3, and columns to what the line memory can hold.
  always_comb begin
    if (grid_cols_r < 11'd3) begin
      cols_eff = CW'(3);
    end else if (32'(grid_cols_r) > MAX_COLS) begin
      cols_eff = CW'(MAX_COLS);
    end else begin
      cols_eff = CW'(grid_cols_r);
    end
    rows_eff = (grid_rows_r < 16'd3) ? 16'd3 : grid_rows_r;
  end

  // ---------------------------------------------------------------------------
  // Handshake and pipeline flow control
  // ---------------------------------------------------------------------------
  logic out_valid_r;
  logic v1_r, v2_r, v3_r, v4_r;
  logic s1_res_r;
  logic ready_out, ready4, ready3, ready2, ready1;
  logic s1_go, s1_fire;
  logic accept;

  assign ready_out = !out_valid_r || !out_stall;
  assign ready4    = !v4_r || ready_out;
  assign ready3    = !v3_r || ready4;
  assign ready2    = !v2_r || ready3;
  // A word that releases no result only updates the memory and window, so it
  // leaves the first stage without waiting for the result stages.
  assign s1_go     = !s1_res_r || ready2;
  assign ready1    = !v1_r || s1_go;
  assign s1_fire   = v1_r && s1_go;

  assign in_stall  = !ready1;
  assign accept    = in_valid && !in_stall;

  // ---------------------------------------------------------------------------
  // Stream position counters
  // ---------------------------------------------------------------------------
  logic [AW-1:0]  in_col_r;
  logic [RW-1:0]  in_row_r;
  logic [AW-1:0]  out_col_r;
  logic [RW-1:0]  out_row_r;
  logic [PDW-1:0] pending_r;

  logic all_in, ev_sample, ev_enter, ev_res;
  logic in_col_last, out_col_last, out_row_last, grid_last;
  logic row_edge, col_edge;
  boxblur_pkg::div_t div_now;

  always_comb begin
    all_in       = in_row_r >= rows_eff;
    // Once every sample is in, any word acts as a flush.
    ev_sample    = !in_command && !all_in;
    ev_enter     = ev_sample || all_in;
    ev_res       = all_in || (ev_sample && (pending_r > PDW'(cols_eff)));
    in_col_last  = CW'(in_col_r) == (cols_eff - CW'(1));
    out_col_last = CW'(out_col_r) == (cols_eff - CW'(1));
    out_row_last = out_row_r == (rows_eff - 16'd1);
    grid_last    = out_col_last && out_row_last;
    row_edge     = (out_row_r == '0) || out_row_last;
    col_edge     = (out_col_r == '0) || out_col_last;
    if (row_edge && col_edge) begin
      div_now = boxblur_pkg::DIV_BY_4;
    end else if (row_edge || col_edge) begin
      div_now = boxblur_pkg::DIV_BY_6;
    end else begin
      div_now = boxblur_pkg::DIV_BY_9;
    end
  end

  // During the flush phase the input column keeps advancing as a virtual
  // position, so the drain reads the last two rows from the line memory.
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wr) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      pending_r <= '0;
    end else if (accept && ev_enter) begin
      if (ev_res && grid_last) begin
        in_col_r  <= '0;
        in_row_r  <= '0;
        out_col_r <= '0;
        out_row_r <= '0;
        pending_r <= '0;
      end else begin
        in_col_r <= in_col_last ? '0 : in_col_r + AW'(1);
        if (ev_sample && in_col_last) begin
          in_row_r <= in_row_r + 16'd1;
        end
        if (ev_res) begin
          out_col_r <= out_col_last ? '0 : out_col_r + AW'(1);
          if (out_col_last) begin
            out_row_r <= out_row_r + 16'd1;
          end
        end
        if (ev_sample && !ev_res) begin
          pending_r <= pending_r + PDW'(1);
        end else if (!ev_sample && ev_res) begin
          pending_r <= pending_r - PDW'(1);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: line memory read, write back and column window
  // ---------------------------------------------------------------------------
  // Each entry holds the two rows above the incoming one at that column.
  // Consecutive words of a stream always address different columns, so a read never
  // meets the write of the same entry in one cycle.
  logic [2*SB-1:0] line_mem [MAX_COLS];
  logic [2*SB-1:0] lb_q;

  logic                  s1_wr_r;
  logic [AW-1:0]         s1_addr_r;
  logic signed [SB-1:0]  s1_sample_r;
  logic                  s1_top_ok_r;
  logic                  s1_mid_ok_r;
  logic                  s1_wrap_r;
  boxblur_pkg::div_t     s1_div_r;
  logic                  s1_done_r;

  logic signed [SB-1:0]  top_val, mid_val, bot_val;
  logic signed [CSW-1:0] col_sum, right_sum;
  logic signed [CSW-1:0] col_l_r, col_m_r;
  logic signed [TW-1:0]  win_total;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (ready1) begin
      v1_r <= accept && ev_enter;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && ev_enter) begin
      s1_wr_r     <= ev_sample;
      s1_res_r    <= ev_res;
      s1_addr_r   <= in_col_r;
      s1_sample_r <= in_height;
      s1_top_ok_r <= in_row_r >= 16'd2;
      s1_mid_ok_r <= in_row_r != '0;
      s1_wrap_r   <= in_col_r == '0;
      s1_div_r    <= div_now;
      s1_done_r   <= grid_last;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && ev_enter) begin
      lb_q <= line_mem[in_col_r];
    end
    if (s1_fire && s1_wr_r) begin
      line_mem[s1_addr_r] <= {mid_val, s1_sample_r};
    end
  end

  always_comb begin
    top_val   = s1_top_ok_r ? $signed(lb_q[2*SB-1:SB]) : '0;
    mid_val   = s1_mid_ok_r ? $signed(lb_q[SB-1:0]) : '0;
    bot_val   = s1_wr_r ? s1_sample_r : '0;
    col_sum   = CSW'(top_val) + CSW'(mid_val) + CSW'(bot_val);
    // At column zero the incoming column starts the next row, and the
    // point being finished sits on the right edge.
    right_sum = s1_wrap_r ? '0 : col_sum;
    win_total = TW'(col_l_r) + TW'(col_m_r) + TW'(right_sum);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_l_r <= '0;
      col_m_r <= '0;
    end else if (s1_fire) begin
      col_l_r <= s1_wrap_r ? '0 : col_m_r;
      col_m_r <= col_sum;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: magnitude plus half divisor
  // ---------------------------------------------------------------------------
  logic signed [TW-1:0] s2_sum_r;
  boxblur_pkg::div_t    s2_div_r;
  logic                 s2_done_r;
  logic                 s2_neg;
  logic [TW-1:0]        abs_sum;
  logic [NW-1:0]        half_div;
  logic [NW-1:0]        n_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (ready2) begin
      v2_r <= v1_r && s1_res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2 && v1_r && s1_res_r) begin
      s2_sum_r  <= win_total;
      s2_div_r  <= s1_div_r;
      s2_done_r <= s1_done_r;
    end
  end

  always_comb begin
    s2_neg  = s2_sum_r[TW-1];
    abs_sum = s2_neg ? (TW'(0) - $unsigned(s2_sum_r)) : $unsigned(s2_sum_r);
    unique case (s2_div_r)
      boxblur_pkg::DIV_BY_4: half_div = NW'(2);
      boxblur_pkg::DIV_BY_6: half_div = NW'(3);
      boxblur_pkg::DIV_BY_9: half_div = NW'(4);
      default:               half_div = NW'(4);
    endcase
    // Ties round away from zero because the half is added to the magnitude.
    n_val = NW'(abs_sum) + half_div;
  end

  // ---------------------------------------------------------------------------
  // Stage 3: reciprocal multiply, split in two partial products
  // ---------------------------------------------------------------------------
  logic [NW-1:0]     s3_n_r;
  logic              s3_neg_r;
  boxblur_pkg::div_t s3_div_r;
  logic              s3_done_r;
  logic [KW-1:0]     k_sel;
  logic [NW+KHW-1:0] prod_hi;
  logic [NW+KLW-1:0] prod_lo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (ready3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ready3 && v2_r) begin
      s3_n_r    <= n_val;
      s3_neg_r  <= s2_neg;
      s3_div_r  <= s2_div_r;
      s3_done_r <= s2_done_r;
    end
  end

  always_comb begin
    unique case (s3_div_r)
      boxblur_pkg::DIV_BY_4: k_sel = K4;
      boxblur_pkg::DIV_BY_6: k_sel = K6;
      boxblur_pkg::DIV_BY_9: k_sel = K9;
      default:               k_sel = K9;
    endcase
    prod_hi = {{KHW{1'b0}}, s3_n_r} * {{NW{1'b0}}, k_sel[KW-1:KLW]};
    prod_lo = {{KLW{1'b0}}, s3_n_r} * {{NW{1'b0}}, k_sel[KLW-1:0]};
  end

  // ---------------------------------------------------------------------------
  // Stage 4: combine partial products, scale down and restore the sign
  // ---------------------------------------------------------------------------
  logic [NW+KHW-1:0]  s4_hi_r;
  logic [NW+KLW-1:0]  s4_lo_r;
  logic               s4_neg_r;
  logic               s4_done_r;
  logic [PW-1:0]      prod_all;
  logic [QW-1:0]      quot;
  logic [QW-1:0]      quot_signed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (ready4) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ready4 && v3_r) begin
      s4_hi_r   <= prod_hi;
      s4_lo_r   <= prod_lo;
      s4_neg_r  <= s3_neg_r;
      s4_done_r <= s3_done_r;
    end
  end

  always_comb begin
    prod_all    = (PW'(s4_hi_r) << KLW) + PW'(s4_lo_r);
    quot        = prod_all[PW-1:SHIFT];
    quot_signed = s4_neg_r ? (QW'(0) - quot) : quot;
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic signed [SB-1:0] out_smoothed_r;
  logic                 out_grid_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ready_out) begin
      out_valid_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_out && v4_r) begin
      out_smoothed_r  <= $signed(quot_signed[SB-1:0]);
      out_grid_done_r <= s4_done_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_smoothed  = out_smoothed_r;
  assign out_grid_done = out_grid_done_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // No more points wait than one row plus one.
  a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= (PDW'(cols_eff) + PDW'(1)))
    else $error("pending count exceeds one row plus one point");

  // Once the whole grid is in, some result must still be owed.
  a_drain_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (in_row_r >= rows_eff) |-> (pending_r != '0))
    else $error("grid fully received with nothing pending");

  // The write pointer stays inside the current row width.
  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(in_col_r) < cols_eff)
    else $error("input column beyond grid width");

  // A sample that releases nothing adds exactly one pending point.
  a_pending_step: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && ev_sample && !ev_res && !cfg_wr) |=>
      (pending_r == ($past(pending_r) + PDW'(1))))
    else $error("pending count did not advance on a sample");

endmodule

`default_nettype wire

### bench/boxblur_checker.sv
`timescale 1ns / 1ps
// Result checker for the 3x3 edge-averaging box blur: it watches the input, result and
// configuration ports, predicts every result word and compares it field by field.
// Depends on boxblur_pkg for the register index and the reset values of the grid size.

module boxblur_checker #(
  parameter int   MAX_COLS    = 1024,
  parameter int   SAMPLE_BITS = 16,
  parameter logic FLUSH_CMD   = 1'b1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          in_command,
  input  logic signed [SAMPLE_BITS-1:0] in_height,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic signed [SAMPLE_BITS-1:0] out_smoothed,
  input  logic                          out_grid_done,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output int                            mismatches,
  output int                            outstanding
);

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] smoothed;
    logic                          grid_done;
  } blur_result_t;

  blur_result_t                  due_means[$];
  logic signed [SAMPLE_BITS-1:0] line_mem [3][MAX_COLS];
  logic [10:0]                   cols_reg;
  logic [15:0]                   rows_reg;
  int                            in_row, in_col, out_row, out_col, backlog;

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  // Register values outside the usable range are clamped by the block.
  function automatic int active_cols();
    if (cols_reg < 3) return 3;
    if (cols_reg > MAX_COLS) return MAX_COLS;
    return int'(cols_reg);
  endfunction

  function automatic int active_rows();
    if (rows_reg < 3) return 3;
    return int'(rows_reg);
  endfunction

  task automatic restart_stream();
    in_row  = 0;
    in_col  = 0;
    out_row = 0;
    out_col = 0;
    backlog = 0;
  endtask

  // Mean over the in-grid part of the 3x3 neighborhood, ties rounded away from zero.
  function automatic logic signed [SAMPLE_BITS-1:0] neighborhood_mean(int r, int c,
                                                                       int ncols, int nrows);
    int total, count, q, dr, dc;
    total = 0;
    count = 0;
    for (dr = -1; dr <= 1; dr++) begin
      for (dc = -1; dc <= 1; dc++) begin
        if (r + dr >= 0 && r + dr < nrows && c + dc >= 0 && c + dc < ncols) begin
          total += line_mem[(r + dr) % 3][c + dc];
          count++;
        end
      end
    end
    if (total >= 0) q = (total + count / 2) / count;
    else q = -((count / 2 - total) / count);
    return q[SAMPLE_BITS-1:0];
  endfunction

  task automatic release_mean(int ncols, int nrows);
    blur_result_t res;
    res.smoothed  = neighborhood_mean(out_row, out_col, ncols, nrows);
    res.grid_done = (out_row + 1 >= nrows) && (out_col + 1 >= ncols);
    due_means.push_back(res);
    backlog--;
    if (res.grid_done) begin
      restart_stream();
    end else begin
      out_col++;
      if (out_col >= ncols) begin
        out_col = 0;
        out_row++;
      end
    end
  endtask

  task automatic blur_step(logic cmd, logic signed [SAMPLE_BITS-1:0] h);
    int   ncols, nrows;
    logic grid_in;
    ncols   = active_cols();
    nrows   = active_rows();
    grid_in = in_row >= nrows;
    if (cmd != FLUSH_CMD && !grid_in) begin
      line_mem[in_row % 3][in_col] = h;
      in_col++;
      if (in_col >= ncols) begin
        in_col = 0;
        in_row++;
      end
      backlog++;
      if (backlog > ncols + 1) release_mean(ncols, nrows);
    end else if (grid_in && backlog > 0) begin
      release_mean(ncols, nrows);
    end
  endtask

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_word();
    blur_result_t want;
    if (due_means.size() == 0) begin
      report_mismatch($sformatf("result word with nothing due (smoothed %0d, grid_done %0b)",
                                out_smoothed, out_grid_done));
      return;
    end
    want = due_means.pop_front();
    if (out_smoothed !== want.smoothed)
      report_mismatch($sformatf("smoothed is %0d, wanted %0d", out_smoothed, want.smoothed));
    if (out_grid_done !== want.grid_done)
      report_mismatch($sformatf("grid_done is %0b, wanted %0b", out_grid_done,
                                want.grid_done));
  endtask

  // A result can never stem from the word accepted at the same edge, so results are
  // checked before the new word is predicted.
  always @(posedge clk) begin
    if (!rst_n) begin
      cols_reg = boxblur_pkg::GRID_COLS_RST;
      rows_reg = boxblur_pkg::GRID_ROWS_RST;
      restart_stream();
      due_means.delete();
    end else begin
      if (out_valid && !out_stall) check_word();
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == boxblur_pkg::REG_GRID_COLS) cols_reg = pwdata[10:0];
        else rows_reg = pwdata[15:0];
        restart_stream();
      end
      if (in_valid && !in_stall) blur_step(in_command, in_height);
    end
    outstanding = due_means.size();
  end

endmodule

### bench/box_blur_3x3_edge_average_test.sv
`timescale 1ns / 1ps
// Top of the testbench for the 3x3 edge-averaging box blur: clock, reset, stimulus,
// idling and the verdict. Depends on boxblur_pkg, the block and boxblur_checker.

module box_blur_3x3_edge_average_test;

  localparam int MAX_COLS       = 1024;
  localparam int SAMPLE_BITS    = 16;
  localparam int CLK_HALF       = 10;
  localparam int WATCHDOG_LIMIT = 2000;
  // A releasing word has to pass the pipeline to reach the output register; SETTLE_CYCLES
  // allows for that before anything that needs the block to be quiet.
  localparam int SETTLE_CYCLES  = 8;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_FLUSH  = 1'b1;

  localparam logic [2:0] COLS_ADDR = {boxblur_pkg::REG_GRID_COLS, 2'b00};
  localparam logic [2:0] ROWS_ADDR = {boxblur_pkg::REG_GRID_ROWS, 2'b00};

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  // Grid geometry per random phase, as written to the registers. Out-of-range values
  // are included on purpose: 0 and 2 columns act as 3, 2047 acts as 1024, and row counts
  // below 3 act as 3. The widest phase is fed only part of a grid, since a whole one
  // would take several thousand words.
  localparam int N_PHASES = 7;
  localparam int PHASE_COLS  [N_PHASES] = '{3, 0, 5, 2, 9, 2047, 7};
  localparam int PHASE_ROWS  [N_PHASES] = '{3, 65535, 4, 7, 3, 2, 5};
  localparam int PHASE_WORDS [N_PHASES] = '{110, 60, 110, 100, 110, 1100, 110};

  // A 3x3 grid of extremes: its top-left corner averages four maximum values, and the
  // other points mix both signs so that rounding is exercised in both directions.
  localparam logic signed [SAMPLE_BITS-1:0] EDGE_GRID [9] = '{
    16'sh7FFF, 16'sh7FFF, 16'sh8000,
    16'sh7FFF, 16'sh7FFF, -16'sd1,
    16'sd1,    -16'sd2,   16'sd3
  };

  logic                          clk           = 1'b0;
  logic                          rst_n         = 1'b0;
  logic                          in_valid      = 1'b0;
  logic                          in_command    = CMD_SAMPLE;
  logic signed [SAMPLE_BITS-1:0] in_height     = '0;
  logic                          out_stall     = 1'b0;
  logic                          psel          = 1'b0;
  logic                          penable       = 1'b0;
  logic                          pwrite        = 1'b0;
  logic [2:0]                    paddr         = '0;
  logic [31:0]                   pwdata        = '0;
  logic                          in_stall;
  logic                          out_valid;
  logic signed [SAMPLE_BITS-1:0] out_smoothed;
  logic                          out_grid_done;
  logic [31:0]                   prdata;
  logic                          pready;

  int sender_idle_pct = 0;
  int stall_pct       = 0;
  int quiet_cycles    = 0;
  int mismatches;
  int outstanding;

  box_blur_3x3_edge_average #(
    .MAX_COLS   (MAX_COLS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_command   (in_command),
    .in_height    (in_height),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_smoothed (out_smoothed),
    .out_grid_done(out_grid_done),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // The checker sits beside the block, sees the same pins and keeps its own model.
  boxblur_checker #(
    .MAX_COLS   (MAX_COLS),
    .SAMPLE_BITS(SAMPLE_BITS),
    .FLUSH_CMD  (CMD_FLUSH)
  ) results_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_command   (in_command),
    .in_height    (in_height),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_smoothed (out_smoothed),
    .out_grid_done(out_grid_done),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  // 20 ns clock period.
  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // The receiver decides each cycle, at the falling edge, whether to stall.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog: any accepted word, taken result or register write counts as progress. A run
  // in which nothing moves until quiet_cycles reaches WATCHDOG_LIMIT is hung and fails.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
        (psel && penable && pwrite && pready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Nonblocking, so the stall process sees a mode change cleanly on the next cycle.
  task automatic set_idling(idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        sender_idle_pct <= 0;
        stall_pct       <= 0;
      end
      IDLE_SENDER: begin
        sender_idle_pct <= 87;
        stall_pct       <= 0;
      end
      IDLE_RECEIVER: begin
        sender_idle_pct <= 0;
        stall_pct       <= 87;
      end
      default: begin
        sender_idle_pct <= 19;
        stall_pct       <= 19;
      end
    endcase
  endtask

  // One register write: setup cycle, then access cycle until pready. It returns at a
  // falling edge with psel still high, so a second write can follow back to back.
  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
  endtask

  // Writes both registers; each write restarts the stream inside the block.
  task automatic set_geometry(int cols, int rows);
    write_reg(COLS_ADDR, 32'(cols));
    write_reg(ROWS_ADDR, 32'(rows));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Presents one input word at a falling edge, after a random idle gap, and holds it
  // until it is taken at a rising edge without stall.
  task automatic send_word(logic cmd, logic signed [SAMPLE_BITS-1:0] h);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_height  <= h;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Heights lean toward the extremes and the values around zero.
  function automatic logic signed [SAMPLE_BITS-1:0] pick_height();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(11))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return -16'sd1;
      3:       return 16'sd0;
      default: return r[SAMPLE_BITS-1:0];
    endcase
  endfunction

  // Whole grids with random heights: the samples in raster order with a stray flush now
  // and then (the block drops those), then one drain word per pending point, where a
  // sample sometimes stands in for the flush, then a few flushes with nothing pending.
  // The phase may end in the middle of a grid; the next register write restarts it.
  task automatic feed_grids(int ncols, int nrows, int budget);
    int sent, idx, extra;
    sent = 0;
    while (sent < budget) begin
      for (idx = 0; idx < ncols * nrows && sent < budget; idx++) begin
        if ($urandom_range(39) == 0) begin
          send_word(CMD_FLUSH, pick_height());
          sent++;
        end
        send_word(CMD_SAMPLE, pick_height());
        sent++;
      end
      if (sent < budget) begin
        for (idx = 0; idx <= ncols; idx++) begin
          send_word(($urandom_range(9) == 0) ? CMD_SAMPLE : CMD_FLUSH, pick_height());
          sent++;
        end
        extra = $urandom_range(2);
        repeat (extra) send_word(CMD_FLUSH, pick_height());
        sent += extra;
      end
    end
  endtask

  // Waits until every predicted result has come out, then lets the pipeline run dry,
  // since words that release nothing may still be in flight.
  task automatic settle();
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    int idx, ncols, nrows;

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. Column count 0 and row count 1 both act as 3, so this is the
    // smallest grid the block handles.
    set_idling(IDLE_NONE);
    set_geometry(0, 1);
    // A flush before the grid is complete is dropped.
    send_word(CMD_FLUSH, 16'sd0);
    for (idx = 0; idx < 9; idx++) send_word(CMD_SAMPLE, EDGE_GRID[idx]);
    // A sample after the last point of the grid acts as a flush; its height is lost.
    send_word(CMD_SAMPLE, 16'sh1234);
    // The remaining pending points drain; the last one carries grid_done.
    repeat (3) send_word(CMD_FLUSH, -16'sd1);
    // Nothing is pending any more, so this flush gives no result.
    send_word(CMD_FLUSH, 16'sd0);
    // A partial grid of minimum values: one result comes out, then the register
    // write of the first random phase restarts the stream in the middle of the grid.
    repeat (5) send_word(CMD_SAMPLE, 16'sh8000);
    in_valid <= 1'b0;
    settle();

    // Random part, walking through the idling modes phase by phase.
    for (int p = 0; p < N_PHASES; p++) begin
      set_idling(idle_mode_t'(p % 4));
      set_geometry(PHASE_COLS[p], PHASE_ROWS[p]);
      ncols = (PHASE_COLS[p] < 3) ? 3 : (PHASE_COLS[p] > MAX_COLS) ? MAX_COLS : PHASE_COLS[p];
      nrows = (PHASE_ROWS[p] < 3) ? 3 : PHASE_ROWS[p];
      feed_grids(ncols, nrows, PHASE_WORDS[p]);
      in_valid <= 1'b0;
      settle();
    end

    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
